// File: src/mcky_pkg.sv
// Shared types, constants and the character classifier for the Morse character keyer.
package mcky_pkg;

   localparam int UNIT_W = 16;
   localparam int DUR_W = 18;
   localparam int CHAR_W = 8;
   localparam int SYM_MAX = 5;
   localparam int LEN_W = 3;
   localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd500;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'd57;

   // Register indexes of the configuration port.
   localparam logic REG_UNIT_TIME = 1'b0;

   // One character as the back end sees it: symbol count and dash mask,
   // bit i set when symbol i is a dash.
   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [SYM_MAX-1:0] dash;
   } sym_code_type;

   typedef struct packed {
      logic         valid;
      sym_code_type code;
   } queue_head_type;

   function automatic sym_code_type letter_code(input logic [4:0] idx);
      sym_code_type r;
      unique case (idx)
         5'd0:    r = '{len: 3'd2, dash: 5'b00010};
         5'd1:    r = '{len: 3'd4, dash: 5'b00001};
         5'd2:    r = '{len: 3'd4, dash: 5'b00101};
         5'd3:    r = '{len: 3'd3, dash: 5'b00001};
         5'd4:    r = '{len: 3'd1, dash: 5'b00000};
         5'd5:    r = '{len: 3'd4, dash: 5'b00100};
         5'd6:    r = '{len: 3'd3, dash: 5'b00011};
         5'd7:    r = '{len: 3'd4, dash: 5'b00000};
         5'd8:    r = '{len: 3'd2, dash: 5'b00000};
         5'd9:    r = '{len: 3'd4, dash: 5'b01110};
         5'd10:   r = '{len: 3'd3, dash: 5'b00101};
         5'd11:   r = '{len: 3'd4, dash: 5'b00010};
         5'd12:   r = '{len: 3'd2, dash: 5'b00011};
         5'd13:   r = '{len: 3'd2, dash: 5'b00001};
         5'd14:   r = '{len: 3'd3, dash: 5'b00111};
         5'd15:   r = '{len: 3'd4, dash: 5'b00110};
         5'd16:   r = '{len: 3'd4, dash: 5'b01011};
         5'd17:   r = '{len: 3'd3, dash: 5'b00010};
         5'd18:   r = '{len: 3'd3, dash: 5'b00000};
         5'd19:   r = '{len: 3'd1, dash: 5'b00001};
         5'd20:   r = '{len: 3'd3, dash: 5'b00100};
         5'd21:   r = '{len: 3'd4, dash: 5'b01000};
         5'd22:   r = '{len: 3'd3, dash: 5'b00110};
         5'd23:   r = '{len: 3'd4, dash: 5'b01001};
         5'd24:   r = '{len: 3'd4, dash: 5'b01101};
         5'd25:   r = '{len: 3'd4, dash: 5'b00011};
         default: r = '{len: 3'd0, dash: 5'b00000};
      endcase
      return r;
   endfunction

   function automatic sym_code_type digit_code(input logic [3:0] idx);
      sym_code_type r;
      unique case (idx)
         4'd0:    r = '{len: 3'd5, dash: 5'b11111};
         4'd1:    r = '{len: 3'd5, dash: 5'b11110};
         4'd2:    r = '{len: 3'd5, dash: 5'b11100};
         4'd3:    r = '{len: 3'd5, dash: 5'b11000};
         4'd4:    r = '{len: 3'd5, dash: 5'b10000};
         4'd5:    r = '{len: 3'd5, dash: 5'b00000};
         4'd6:    r = '{len: 3'd5, dash: 5'b00001};
         4'd7:    r = '{len: 3'd5, dash: 5'b00011};
         4'd8:    r = '{len: 3'd5, dash: 5'b00111};
         4'd9:    r = '{len: 3'd5, dash: 5'b01111};
         default: r = '{len: 3'd0, dash: 5'b00000};
      endcase
      return r;
   endfunction

   // Characters outside the tables, the slash among them, carry no symbols.
   function automatic sym_code_type classify(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] up_off;
      logic [CHAR_W-1:0] lo_off;
      logic [CHAR_W-1:0] dg_off;
      sym_code_type      r;
      up_off = c - CHAR_UPPER_A;
      lo_off = c - CHAR_LOWER_A;
      dg_off = c - CHAR_DIGIT_0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = letter_code(up_off[4:0]);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = letter_code(lo_off[4:0]);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r = digit_code(dg_off[3:0]);
      end else begin
         r = '{len: 3'd0, dash: 5'b00000};
      end
      return r;
   endfunction

endpackage

// File: src/morse_character_keyer.sv
// A character is written into the queue, then into the segment output register once the
// back-end sequencer is idle and not stalled. The sequencer emits one segment per cycle
// unless rsp_stall holds it; a character gives 2*n+1 segments for n symbols (0 to 5).
// The input takes a new item every cycle until the QUEUE_DEPTH-entry queue fills.
// Reset is synchronous: it empties the queue, idles the sequencer and sets unit_time to 500.
module morse_character_keyer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mcky_pkg::CHAR_W-1:0]   req_char_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_led_on,
   output logic [mcky_pkg::DUR_W-1:0]    rsp_duration_time,
   output logic                          rsp_last_segment,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [mcky_pkg::UNIT_W-1:0] unit_ff;
   logic                        csr_write;
   logic                        queue_full;
   logic                        push;
   mcky_pkg::sym_code_type      push_code;
   logic                        pop;
   mcky_pkg::queue_head_type    head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= mcky_pkg::UNIT_RESET;
      end else if (csr_write && paddr[2] == mcky_pkg::REG_UNIT_TIME) begin
         unit_ff <= pwdata[mcky_pkg::UNIT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == mcky_pkg::REG_UNIT_TIME) begin
         prdata = {16'd0, unit_ff};
      end
   end

   mcky_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .queue_full    (queue_full),
      .push          (push),
      .push_code     (push_code)
   );

   mcky_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_code (push_code),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   mcky_back u_back (
      .clock             (clock),
      .reset             (reset),
      .unit_time         (unit_ff),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_duration_time (rsp_duration_time),
      .rsp_last_segment  (rsp_last_segment)
   );

endmodule

// File: src/mcky_front.sv
// Front end: takes character items and classifies them into symbol codes.
module mcky_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mcky_pkg::CHAR_W-1:0]  req_char_code,
   input  logic                         queue_full,
   output logic                         push,
   output mcky_pkg::sym_code_type       push_code
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign push_code = mcky_pkg::classify(req_char_code);

endmodule

// File: src/mcky_queue.sv
// Short queue of classified characters between the front and back ends.
module mcky_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  mcky_pkg::sym_code_type        push_code,
   output logic                          full,
   input  logic                          pop,
   output mcky_pkg::queue_head_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mcky_pkg::sym_code_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.code  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_code;
      end
   end

endmodule

// File: src/mcky_back.sv
// Back end: steps through the symbols of each character and drives the segment register.
module mcky_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mcky_pkg::UNIT_W-1:0]   unit_time,
   input  mcky_pkg::queue_head_type      head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_led_on,
   output logic [mcky_pkg::DUR_W-1:0]    rsp_duration_time,
   output logic                          rsp_last_segment
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MARK  = 4'b0010,
      S_SPACE = 4'b0100,
      S_GAP   = 4'b1000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   mcky_pkg::sym_code_type         code_ff, code_in;
   logic [mcky_pkg::LEN_W-1:0]     idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic                           led_ff, led_in;
   logic [mcky_pkg::DUR_W-1:0]     dur_ff, dur_in;
   logic                           last_ff, last_in;
   logic [mcky_pkg::DUR_W-1:0]     one_unit;
   logic [mcky_pkg::DUR_W-1:0]     three_units;
   logic                           advance;

   assign one_unit    = {2'b00, unit_time};
   assign three_units = one_unit + {1'b0, unit_time, 1'b0};
   assign advance     = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      led_in   = led_ff;
      dur_in   = dur_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (advance) begin
         valid_in = 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               // The first segment is registered in the same cycle the queue is popped.
               if (head.valid) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  code_in  = head.code;
                  idx_in   = '0;
                  if (head.code.len == '0) begin
                     led_in  = 1'b0;
                     dur_in  = three_units;
                     last_in = 1'b1;
                  end else begin
                     led_in   = 1'b1;
                     dur_in   = head.code.dash[0] ? three_units : one_unit;
                     last_in  = 1'b0;
                     state_in = S_SPACE;
                  end
               end
            end
            S_MARK: begin
               valid_in = 1'b1;
               led_in   = 1'b1;
               dur_in   = code_ff.dash[idx_ff] ? three_units : one_unit;
               last_in  = 1'b0;
               state_in = S_SPACE;
            end
            S_SPACE: begin
               valid_in = 1'b1;
               led_in   = 1'b0;
               dur_in   = one_unit;
               last_in  = 1'b0;
               if (idx_ff == code_ff.len - 1'b1) begin
                  state_in = S_GAP;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_MARK;
               end
            end
            S_GAP: begin
               valid_in = 1'b1;
               led_in   = 1'b0;
               dur_in   = three_units;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      idx_ff  <= idx_in;
      led_ff  <= led_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_led_on        = led_ff;
   assign rsp_duration_time = dur_ff;
   assign rsp_last_segment  = last_ff;

`ifndef NO_ASSERTIONS
   a_last_is_dark: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> !led_ff)
      else $error("final segment of an item has the LED lit");

   a_space_is_one_unit: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !led_ff && !last_ff |-> dur_ff == one_unit)
      else $error("space between symbols is not one unit");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK || state_ff == S_SPACE |-> idx_ff < code_ff.len)
      else $error("symbol index ran past the symbol count");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE && head.valid && advance)
      else $error("queue popped while a character is still in progress");
`endif

endmodule

// File: sim/morse_character_keyer_tb.sv
// Self-checking testbench for the Morse character keyer: characters in, timed LED segments out.
`timescale 1ns / 1ps

module morse_character_keyer_tb;

   localparam int STALL_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int PHASE_COUNT = 6;
   localparam logic [2:0] UNIT_TIME_ADDR = 3'(4 * mcky_pkg::REG_UNIT_TIME);

   // Letter and digit extremes, the slash, the codes that border the tables, both ends
   // of the code range, and single-symbol and longer letters and digits.
   localparam logic [mcky_pkg::CHAR_W-1:0] DIRECTED_CHARS[24] = '{
      "A", "Z", "a", "z", "0", "9", "/", 8'd0, 8'd255, 8'd91, 8'd96, 8'd123,
      8'd47, 8'd58, 8'd64, 8'd127, 8'd128, "E", "T", "Q", "J", "5", "Y", "0"
   };

   typedef struct packed {
      logic                       led_on;
      logic [mcky_pkg::DUR_W-1:0] duration_time;
      logic                       last_segment;
   } segment_type;

   class segment_ledger;
      segment_type                 pending_segments[$];
      logic [mcky_pkg::UNIT_W-1:0] unit_ms;
      int unsigned                 fail_count;

      function new();
         unit_ms = mcky_pkg::UNIT_RESET;
         fail_count = 0;
      endfunction

      // Dots and dashes of one character; anything off the tables sends no symbols.
      function string symbols_of(logic [mcky_pkg::CHAR_W-1:0] c);
         if (c >= "a" && c <= "z") c = c - 8'd32;
         case (c)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            default: return "";
         endcase
      endfunction

      function void note_char(logic [mcky_pkg::CHAR_W-1:0] c);
         string                      syms;
         logic [mcky_pkg::DUR_W-1:0] one_unit;
         logic [mcky_pkg::DUR_W-1:0] three_units;
         syms = symbols_of(c);
         one_unit = mcky_pkg::DUR_W'(unit_ms);
         three_units = mcky_pkg::DUR_W'(one_unit * 3);
         for (int i = 0; i < syms.len(); i++) begin
            pending_segments.push_back('{1'b1, (syms[i] == "-") ? three_units : one_unit,
                                         1'b0});
            pending_segments.push_back('{1'b0, one_unit, 1'b0});
         end
         pending_segments.push_back('{1'b0, three_units, 1'b1});
      endfunction

      function void check_segment(segment_type got);
         segment_type want;
         if (pending_segments.size() == 0) begin
            $error("segment with no character pending: led_on %0d duration_time %0d",
                   got.led_on, got.duration_time);
            fail_count++;
            return;
         end
         want = pending_segments.pop_front();
         if (got.led_on !== want.led_on) begin
            $error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
            fail_count++;
         end
         if (got.duration_time !== want.duration_time) begin
            $error("duration_time: expected %0d, got %0d", want.duration_time,
                   got.duration_time);
            fail_count++;
         end
         if (got.last_segment !== want.last_segment) begin
            $error("last_segment: expected %0d, got %0d", want.last_segment,
                   got.last_segment);
            fail_count++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [mcky_pkg::CHAR_W-1:0] req_char_code = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_led_on;
   logic [mcky_pkg::DUR_W-1:0]  rsp_duration_time;
   logic                        rsp_last_segment;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [2:0]                  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   segment_ledger ledger = new();
   int unsigned   req_idle_pct = 23;
   int unsigned   rsp_idle_pct = 23;
   int unsigned   rsp_hold_cycles = 0;
   int unsigned   quiet_cycles = 0;

   morse_character_keyer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_on        (rsp_led_on),
      .rsp_duration_time (rsp_duration_time),
      .rsp_last_segment  (rsp_last_segment),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, or for a whole hold-off once one is requested.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_char(req_char_code);
         if (rsp_valid && !rsp_stall) begin
            ledger.check_segment('{rsp_led_on, rsp_duration_time, rsp_last_segment});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic [mcky_pkg::CHAR_W-1:0] random_char();
      case ($urandom_range(9)) inside
         [0:2]:   return mcky_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
         [3:5]:   return mcky_pkg::CHAR_LOWER_A + 8'($urandom_range(25));
         [6:7]:   return mcky_pkg::CHAR_DIGIT_0 + 8'($urandom_range(9));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_char(input logic [mcky_pkg::CHAR_W-1:0] c);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop sending and let every pending segment come out before going on.
   task automatic drain_segments();
      req_valid <= 1'b0;
      while (ledger.pending_segments.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic read_unit_time();
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= UNIT_TIME_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got[mcky_pkg::UNIT_W-1:0] !== ledger.unit_ms) begin
         $error("unit_time: expected %0d, got %0d", ledger.unit_ms,
                got[mcky_pkg::UNIT_W-1:0]);
         ledger.fail_count++;
      end
   endtask

   task automatic program_unit_time(input logic [mcky_pkg::UNIT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= UNIT_TIME_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      ledger.unit_ms = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      read_unit_time();
   endtask

   initial begin
      logic [mcky_pkg::UNIT_W-1:0] unit_val;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      read_unit_time();

      foreach (DIRECTED_CHARS[i]) send_char(DIRECTED_CHARS[i]);
      drain_segments();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       unit_val = 16'd1;
            1:       unit_val = 16'hFFFF;
            3:       unit_val = 16'd0;
            5:       unit_val = 16'd3;
            default: unit_val = 16'($urandom_range(65535, 1));
         endcase
         program_unit_time(unit_val);
         // One phase runs with no idling on either side.
         req_idle_pct = (p == 1) ? 0 : 23;
         rsp_idle_pct = (p == 1) ? 0 : 23;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == 2 && k == 20) begin
               // Hold the receiver long enough for the queue to fill and stall the input.
               req_valid <= 1'b0;
               @(posedge clock);
               rsp_hold_cycles = 300;
               @(negedge clock);
            end
            if (p == 4 && k == 30) drain_segments();
            send_char(random_char());
         end
         drain_segments();
      end

      if (ledger.fail_count == 0 && ledger.pending_segments.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/mcky_pkg.sv
src/mcky_front.sv
src/mcky_queue.sv
src/mcky_back.sv
src/morse_character_keyer.sv
sim/morse_character_keyer_tb.sv
